// ===== hw/rtl/rsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN stack calculator package
// Shared constants and command codes for the stack calculator.
// ----------------------------------------------------------------------------
package rsc_pkg;

	localparam int StackDepth = 128;
	localparam int PtrW = $clog2(StackDepth + 1);
	localparam int AddrW = $clog2(StackDepth);
	localparam int WordW = 32;
	localparam int CountW = 8;

	typedef enum logic [2:0] {
		CMD_PUSH = 3'd0,
		CMD_SUB  = 3'd1,
		CMD_DIV  = 3'd2,
		CMD_ADD  = 3'd3,
		CMD_MUL  = 3'd4,
		CMD_SQRT = 3'd5,
		CMD_OUT  = 3'd6,
		CMD_HALT = 3'd7
	} cmd_t;

endpackage

// ===== hw/rtl/rpn_stack_calculator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN stack calculator
// Command-driven stack calculator on 32-bit signed words.
// ----------------------------------------------------------------------------
// One command word is taken at a time and answered by exactly one result word.
// The next command word is accepted only after that result word is taken.
// The stack memory has one write port and one registered read port, so an
// operand appears in the cycle after its address. Halt goes straight to the
// response state; push writes first; the others pop operands, then execute.
// Division and square root share one iterative state and its registers, which
// retire one quotient bit or one root bit pair per cycle.
// A pop that finds the stack empty skips its memory read and its wait state.
// The stack memory needs no clearing after reset.
module rpn_stack_calculator
	import rsc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        command,
	input  logic signed [31:0] operand,
	output logic              res_valid,
	input  logic              res_ready,
	output logic              out_valid,
	output logic signed [31:0] out_value,
	output logic [7:0]        stack_count,
	output logic              empty_error,
	output logic              full_error,
	output logic              math_error,
	output logic              halted
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_RDA, ST_WA, ST_RDB, ST_WB, ST_EXEC, ST_ITER, ST_FIX,
		ST_MUL, ST_WRITE, ST_RESP
	} state_t;

	state_t state_q;
	logic [WordW-1:0] mem [StackDepth];
	logic [WordW-1:0] rd_data_q;
	logic [AddrW-1:0] rd_addr;
	logic             wr_en;
	logic [AddrW-1:0] wr_addr;
	logic [WordW-1:0] wr_data;

	logic [PtrW-1:0]  sp_q;
	logic             empty_q, halt_q;
	cmd_t             cmd_q;
	logic [WordW-1:0] a_q, b_q, r_q;
	logic [WordW-1:0] rem_q, quo_q, den_q;
	logic [5:0]       iter_q;
	logic             neg_q, math_q;
	logic [WordW-1:0] mul_full;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_data_q <= mem[rd_addr];
	end

	assign rd_addr = AddrW'(sp_q - PtrW'(1));
	assign mul_full = b_q * a_q;

	// Divider step (restoring) and root step (digit-by-digit).
	logic [WordW:0]   div_trial;
	logic [WordW-1:0] div_rem_sh;
	logic [WordW-1:0] sq_bit, sq_sum;
	assign div_rem_sh = {rem_q[WordW-2:0], quo_q[WordW-1]};
	assign div_trial = {1'b0, div_rem_sh} - {1'b0, den_q};
	assign sq_bit = 32'h4000_0000 >> {iter_q[4:0], 1'b0};
	assign sq_sum = quo_q + sq_bit;

	always_comb begin
		wr_en = 1'b0;
		wr_addr = AddrW'(sp_q);
		wr_data = r_q;
		if (state_q == ST_WRITE && sp_q < PtrW'(StackDepth)) begin
			wr_en = 1'b1;
		end
	end

	assign in_ready = (state_q == ST_IDLE) && !res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sp_q <= '0;
			empty_q <= 1'b0;
			halt_q <= 1'b0;
			res_valid <= 1'b0;
			out_valid <= 1'b0;
			out_value <= '0;
			full_error <= 1'b0;
			math_error <= 1'b0;
			iter_q <= '0;
		end else begin
			if (res_valid && res_ready) res_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						cmd_q <= cmd_t'(command);
						out_valid <= 1'b0;
						out_value <= '0;
						full_error <= 1'b0;
						math_error <= 1'b0;
						math_q <= 1'b0;
						a_q <= '0;
						b_q <= '0;
						if (halt_q) begin
							state_q <= ST_RESP;
						end else begin
							case (cmd_t'(command))
								CMD_PUSH: begin
									empty_q <= 1'b0;
									if (sp_q >= PtrW'(StackDepth)) begin
										full_error <= 1'b1;
										state_q <= ST_RESP;
									end else begin
										r_q <= operand;
										state_q <= ST_WRITE;
									end
								end
								CMD_HALT: begin
									halt_q <= 1'b1;
									state_q <= ST_RESP;
								end
								default: state_q <= ST_RDA;
							endcase
						end
					end
				end
				ST_RDA: begin
					if (empty_q || sp_q == '0) begin
						empty_q <= 1'b1;
						a_q <= '0;
						state_q <= (cmd_q == CMD_SQRT || cmd_q == CMD_OUT) ? ST_EXEC : ST_RDB;
					end else begin
						sp_q <= sp_q - PtrW'(1);
						state_q <= ST_WA;
					end
				end
				ST_WA: begin
					a_q <= rd_data_q;
					state_q <= (cmd_q == CMD_SQRT || cmd_q == CMD_OUT) ? ST_EXEC : ST_RDB;
				end
				ST_RDB: begin
					if (empty_q || sp_q == '0) begin
						empty_q <= 1'b1;
						b_q <= '0;
						state_q <= ST_EXEC;
					end else begin
						sp_q <= sp_q - PtrW'(1);
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					b_q <= rd_data_q;
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					case (cmd_q)
						CMD_OUT: begin
							out_valid <= 1'b1;
							out_value <= a_q;
							state_q <= ST_RESP;
						end
						CMD_SUB: begin
							r_q <= b_q - a_q;
							state_q <= ST_WRITE;
						end
						CMD_ADD: begin
							r_q <= b_q + a_q;
							state_q <= ST_WRITE;
						end
						CMD_MUL: state_q <= ST_MUL;
						CMD_DIV: begin
							if (a_q == '0) begin
								r_q <= '0;
								math_q <= 1'b1;
								state_q <= ST_WRITE;
							end else begin
								rem_q <= '0;
								quo_q <= b_q[31] ? (~b_q + 32'd1) : b_q;
								den_q <= a_q[31] ? (~a_q + 32'd1) : a_q;
								neg_q <= a_q[31] ^ b_q[31];
								iter_q <= '0;
								state_q <= ST_ITER;
							end
						end
						CMD_SQRT: begin
							if (a_q[31]) begin
								r_q <= '0;
								math_q <= 1'b1;
								state_q <= ST_WRITE;
							end else begin
								rem_q <= a_q;
								quo_q <= '0;
								iter_q <= '0;
								state_q <= ST_ITER;
							end
						end
						default: state_q <= ST_RESP;
					endcase
				end
				ST_ITER: begin
					iter_q <= iter_q + 6'd1;
					if (cmd_q == CMD_DIV) begin
						if (!div_trial[WordW]) begin
							rem_q <= div_trial[WordW-1:0];
							quo_q <= {quo_q[WordW-2:0], 1'b1};
						end else begin
							rem_q <= div_rem_sh;
							quo_q <= {quo_q[WordW-2:0], 1'b0};
						end
						if (iter_q == 6'd31) state_q <= ST_FIX;
					end else begin
						if (rem_q >= sq_sum) begin
							rem_q <= rem_q - sq_sum;
							quo_q <= (quo_q >> 1) + sq_bit;
						end else begin
							quo_q <= quo_q >> 1;
						end
						if (iter_q == 6'd15) state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					if (cmd_q == CMD_DIV && neg_q) r_q <= ~quo_q + 32'd1;
					else r_q <= quo_q;
					state_q <= ST_WRITE;
				end
				ST_MUL: begin
					r_q <= mul_full;
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					empty_q <= 1'b0;
					math_error <= math_q;
					if (sp_q < PtrW'(StackDepth)) sp_q <= sp_q + PtrW'(1);
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					res_valid <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign stack_count = CountW'(sp_q);
	assign empty_error = empty_q;
	assign halted = halt_q;

endmodule

// ===== hw/rtl/rsc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN stack calculator checker
// Port-level assertions for the stack calculator.
// ----------------------------------------------------------------------------
module rsc_checker
	import rsc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic        out_valid,
	input logic [31:0] out_value,
	input logic [7:0]  stack_count,
	input logic        halted,
	input logic        math_error,
	input logic        full_error
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(out_value))
		else $error("Result word changed while stalled.");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted |=> halted)
		else $error("Halt flag dropped.");

	a_halt_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && halted && $past(halted) && $past(res_valid) == 1'b0 |->
		!out_valid && !math_error && !full_error)
		else $error("Halted block reported activity.");

	a_one_at_time: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !in_ready)
		else $error("Input taken while a result word waits.");

endmodule

bind rpn_stack_calculator rsc_checker u_rsc_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.res_valid(res_valid), .res_ready(res_ready), .out_valid(out_valid),
	.out_value(out_value), .stack_count(stack_count), .halted(halted),
	.math_error(math_error), .full_error(full_error)
);
